>>> src/sng_pkg.sv
// ----------------------------------------------------------------------------
// sng_pkg: shared types and constants of the Sobel non-maximum suppression core
// Frame geometry, memory sizes, sector codes, state encoding and the Sobel
// tap tables used by the core, its result queue and its interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sng_pkg;

  // Frame geometry
  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 4095;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = 12;
  localparam int WIDTH_W      = 11;
  localparam int POS_W        = 22;
  localparam int LINE_SEL_W   = 2;
  localparam int LINE_ADDR_W  = LINE_SEL_W + COL_W;
  localparam int LINE_DEPTH   = 4 * MAX_WIDTH;

  // Payload widths
  localparam int PIX_W        = 8;
  localparam int MAG_W        = 11;
  localparam int DIR_W        = 2;
  localparam int MAGDIR_W     = MAG_W + DIR_W;
  localparam int GRAD_W       = 12;
  localparam int SQ_IN_W      = 2 * MAG_W;

  // Result queue
  localparam int QDEPTH       = 2 * MAX_WIDTH + 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam logic [WIDTH_W-1:0]   WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [ROW_W-1:0]     HEIGHT_RESET = ROW_W'(480);

  // Item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Q15 tangents of 22.5 and 67.5 degrees
  localparam logic [13:0] TAN_LOW_Q15  = 14'd13573;
  localparam logic [16:0] TAN_HIGH_Q15 = 17'd79109;

  typedef enum logic [DIR_W-1:0] {
    DIR_HORZ      = 2'd0,
    DIR_DIAG_SAME = 2'd1,
    DIR_VERT      = 2'd2,
    DIR_DIAG_OPP  = 2'd3
  } dir_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PLAN,
    S_MAG_NEXT,
    S_MAG_RD,
    S_MAG_LAST,
    S_MAG_MUL,
    S_MAG_DIR,
    S_MAG_SQRT,
    S_JUDGE_CHK,
    S_JUDGE_A,
    S_JUDGE_B,
    S_JUDGE_D,
    S_POP,
    S_POP_DATA
  } sng_state_e;

  typedef struct packed {
    logic               frame_end;
    logic [MAG_W-1:0]   strength;
  } q_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } q_ctrl_t;

  // Row offset of a Sobel tap: 0 above, 1 same row, 2 below.
  function automatic logic [1:0] tap_row(input logic [2:0] tap);
    logic [1:0] r;
    unique case (tap)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // Column offset of a Sobel tap: 0 left, 1 same column, 2 right.
  function automatic logic [1:0] tap_col(input logic [2:0] tap);
    logic [1:0] c;
    unique case (tap)
      3'd0, 3'd3, 3'd5: c = 2'd0;
      3'd1, 3'd6:       c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  // Contribution of one tap to gx.
  function automatic logic signed [GRAD_W-1:0] tap_gx(input logic [2:0] tap,
                                                      input logic [PIX_W-1:0] pix);
    logic signed [GRAD_W-1:0] p;
    logic signed [GRAD_W-1:0] t;
    p = signed'({{(GRAD_W-PIX_W){1'b0}}, pix});
    unique case (tap)
      3'd0, 3'd5: t = -p;
      3'd2, 3'd7: t = p;
      3'd3:       t = -(p <<< 1);
      3'd4:       t = p <<< 1;
      default:    t = '0;
    endcase
    return t;
  endfunction

  // Contribution of one tap to gy.
  function automatic logic signed [GRAD_W-1:0] tap_gy(input logic [2:0] tap,
                                                      input logic [PIX_W-1:0] pix);
    logic signed [GRAD_W-1:0] p;
    logic signed [GRAD_W-1:0] t;
    p = signed'({{(GRAD_W-PIX_W){1'b0}}, pix});
    unique case (tap)
      3'd0, 3'd2: t = -p;
      3'd5, 3'd7: t = p;
      3'd1:       t = -(p <<< 1);
      3'd6:       t = p <<< 1;
      default:    t = '0;
    endcase
    return t;
  endfunction

  // Circular queue pointer step.
  function automatic logic [QPTR_W-1:0] qptr_next(input logic [QPTR_W-1:0] ptr);
    return (ptr == QPTR_W'(QDEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
  endfunction

endpackage

`default_nettype wire

>>> src/sng_if.sv
// ----------------------------------------------------------------------------
// sng_if: request channels of the Sobel non-maximum suppression core
// Pixel input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sng_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [sng_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, kind, pixel, input ready);
  modport sink   (input valid, kind, pixel, output ready);
endinterface

interface sng_out_if;
  logic                       valid;
  logic                       ready;
  logic [sng_pkg::MAG_W-1:0]  edge_strength;
  logic                       frame_end;

  modport source (output valid, edge_strength, frame_end, input ready);
  modport sink   (input valid, edge_strength, frame_end, output ready);
endinterface

interface sng_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sng_pkg::CFG_IDX_W-1:0]   index;
  logic [sng_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/sng_sqrt.sv
// ----------------------------------------------------------------------------
// sng_sqrt: iterative integer square root
// Restoring digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sng_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sng_pkg::SQ_IN_W-1:0] radicand_i,
  output logic                        done_o,
  output logic [sng_pkg::MAG_W-1:0]   root_o
);
  import sng_pkg::*;

  localparam int STEPS = MAG_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam int REM_W = MAG_W + 2;
  localparam int TRY_W = REM_W + 2;

  logic [SQ_IN_W-1:0] rad_q;
  logic [REM_W-1:0]   rem_q;
  logic [MAG_W-1:0]   root_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [TRY_W-1:0]   rem_t;
  logic [TRY_W-1:0]   trial;
  logic               take;

  // One trial subtraction per cycle.
  always_comb begin
    rem_t = {rem_q, rad_q[SQ_IN_W-1 -: 2]};
    trial = {{(TRY_W-MAG_W-2){1'b0}}, root_q, 2'b01};
    take  = (rem_t >= trial);
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath of the iteration.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[SQ_IN_W-3:0], 2'b00};
      if (take) begin
        rem_q  <= REM_W'(rem_t - trial);
        root_q <= {root_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_q  <= REM_W'(rem_t);
        root_q <= {root_q[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

>>> src/sng_queue.sv
// ----------------------------------------------------------------------------
// sng_queue: result queue
// Circular buffer of judged results in raster order, held in one memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sng_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sng_pkg::q_ctrl_t  ctrl_i,
  input  sng_pkg::q_entry_t wdata_i,
  output sng_pkg::q_entry_t rdata_o,
  output logic              empty_o
);
  import sng_pkg::*;

  q_entry_t          mem [QDEPTH];
  q_entry_t          rdata_q;
  logic [QPTR_W-1:0] head_q;
  logic [QPTR_W-1:0] tail_q;
  logic [QCNT_W-1:0] count_q;
  logic              push_ok;
  logic              pop_ok;

  // A full queue drops the pushed entry.
  assign push_ok = ctrl_i.push && (count_q != QCNT_W'(QDEPTH));
  assign pop_ok  = ctrl_i.pop && (count_q != '0);

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[tail_q] <= wdata_i;
    end
    if (pop_ok) begin
      rdata_q <= mem[head_q];
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (ctrl_i.clear) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_ok) begin
        tail_q <= qptr_next(tail_q);
      end
      if (pop_ok) begin
        head_q <= qptr_next(head_q);
      end
      if (push_ok && !pop_ok) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  assign rdata_o = rdata_q;
  assign empty_o = (count_q == '0);

endmodule

`default_nettype wire

>>> src/sobel_gradient_nonmax_suppress_core.sv
// ----------------------------------------------------------------------------
// sobel_gradient_nonmax_suppress_core: Sobel gradient with non-maximum
// suppression
// Takes grey pixels in raster order and returns thinned edge strengths.
// ----------------------------------------------------------------------------
// The core takes one item at a time and works on it until the oldest queued
// result, if any, is in the output register; the output register lets the
// next item in while that result waits. A pixel item goes through bookkeeping
// and then forms each gradient magnitude it completes (zero to four: one
// in the middle of a row, two at a row end, up to four in the last row), each
// from eight reads of the pixel line memory and eleven steps of the
// bit-serial square root, and then reads the magnitude line memory for
// each position it judges. The last pixel of a frame judges all remaining
// positions, about 2*frame_width+2 of them, and takes correspondingly longer.
// A flush item goes through the same bookkeeping. Configuration writes are
// taken at any time; writes of the frame width or height restart the stream;
// line memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sobel_gradient_nonmax_suppress_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  sng_in_if.sink     stream_i,
  sng_out_if.source  result_o,
  sng_cfg_if.sink    cfg_i
);
  import sng_pkg::*;

  // Frame configuration
  logic [WIDTH_W-1:0] width_q;
  logic [ROW_W-1:0]   height_q;
  logic [POS_W-1:0]   total_q;
  logic [POS_W:0]     total_prod;
  logic [WIDTH_W-1:0] cfg_width;
  logic [ROW_W-1:0]   cfg_height;
  logic               cfg_we;
  logic               restart;

  // Sequencer
  sng_state_e state_q, state_d;

  // Stream positions
  logic [COL_W-1:0] in_col_q;
  logic [ROW_W-1:0] in_row_q;
  logic [POS_W-1:0] in_pos_q;
  logic [POS_W-1:0] out_pos_q;
  logic [ROW_W-1:0] out_row_q;
  logic [COL_W-1:0] out_col_q;

  // Current item
  logic       kind_q;
  logic       last_q;
  logic [3:0] jobs_q;

  // Magnitude forming
  logic [ROW_W-1:0]             job_y_q;
  logic [COL_W-1:0]             job_x_q;
  logic [2:0]                   tap_q;
  logic [2:0]                   acc_tap_q;
  logic                         acc_vld_q;
  logic signed [GRAD_W-1:0]     gx_q, gy_q;
  logic [MAG_W-1:0]             ax, ay;
  logic [2*MAG_W-1:0]           ax2_q, ay2_q;
  logic [MAG_W+14:0]            ay_sh_q;
  logic [MAG_W+16:0]            lo_q, hi_q;
  logic                         same_sign_q;
  dir_e                         dir_q;
  dir_e                         dir_d;
  logic [SQ_IN_W:0]             sq_sum;
  logic                         sqrt_start;
  logic                         sqrt_done;
  logic [MAG_W-1:0]             sqrt_root;

  // Line memories
  logic [PIX_W-1:0]       pix_mem [LINE_DEPTH];
  logic [MAGDIR_W-1:0]    mag_mem [LINE_DEPTH];
  logic [PIX_W-1:0]       pix_rdata_q;
  logic [MAGDIR_W-1:0]    mag_rdata_q;
  logic [LINE_ADDR_W-1:0] pix_raddr;
  logic [LINE_ADDR_W-1:0] mag_raddr;
  logic                   mag_we;

  // Judging
  logic [MAGDIR_W-1:0] jc_q;
  logic [MAG_W-1:0]    na_q;
  logic                judge_go;
  logic                border;
  logic                frame_last;
  logic [MAG_W-1:0]    judged;

  // Result queue and output register
  q_ctrl_t  q_ctrl;
  q_entry_t q_wdata;
  q_entry_t q_rdata;
  logic     q_empty;
  logic     out_valid_q;
  q_entry_t out_data_q;
  logic     in_acc;

  // --------------------------------------------------------------------------
  // Configuration port: clamp the values and restart the stream on a width or height write.
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign restart     = cfg_we && ((cfg_i.index == CFG_IDX_FRAME_WIDTH) ||
                                  (cfg_i.index == CFG_IDX_FRAME_HEIGHT));

  always_comb begin
    cfg_width = cfg_i.data[WIDTH_W-1:0];
    if (cfg_width < WIDTH_W'(3)) begin
      cfg_width = WIDTH_W'(3);
    end else if (cfg_width > WIDTH_W'(MAX_WIDTH)) begin
      cfg_width = WIDTH_W'(MAX_WIDTH);
    end
    cfg_height = cfg_i.data[ROW_W-1:0];
    if (cfg_height < ROW_W'(3)) begin
      cfg_height = ROW_W'(3);
    end else if (cfg_height > ROW_W'(HEIGHT_LIMIT)) begin
      cfg_height = ROW_W'(HEIGHT_LIMIT);
    end
  end

  assign total_prod = {{(POS_W+1-WIDTH_W){1'b0}}, width_q} *
                      {{(POS_W+1-ROW_W){1'b0}}, height_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      total_q  <= POS_W'(int'(WIDTH_RESET) * int'(HEIGHT_RESET));
    end else begin
      total_q <= total_prod[POS_W-1:0];
      if (cfg_we && (cfg_i.index == CFG_IDX_FRAME_WIDTH)) begin
        width_q <= cfg_width;
      end
      if (cfg_we && (cfg_i.index == CFG_IDX_FRAME_HEIGHT)) begin
        height_q <= cfg_height;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pixel line memory: written when a pixel is accepted, read one Sobel tap per cycle.
  // --------------------------------------------------------------------------
  assign in_acc = stream_i.valid && stream_i.ready;

  always_comb begin
    logic [ROW_W-1:0] ry;
    logic [COL_W-1:0] rx;
    unique case (tap_row(tap_q))
      2'd0:    ry = (job_y_q == '0) ? ROW_W'(1) : job_y_q - ROW_W'(1);
      2'd1:    ry = job_y_q;
      default: ry = (({1'b0, job_y_q} + (ROW_W+1)'(1)) >= {1'b0, height_q}) ?
                    height_q - ROW_W'(2) : job_y_q + ROW_W'(1);
    endcase
    unique case (tap_col(tap_q))
      2'd0:    rx = (job_x_q == '0) ? COL_W'(1) : job_x_q - COL_W'(1);
      2'd1:    rx = job_x_q;
      default: rx = (({1'b0, job_x_q} + WIDTH_W'(1)) >= width_q) ?
                    COL_W'(width_q - WIDTH_W'(2)) : job_x_q + COL_W'(1);
    endcase
    pix_raddr = {ry[LINE_SEL_W-1:0], rx};
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (stream_i.kind == KIND_PIXEL)) begin
      pix_mem[{in_row_q[LINE_SEL_W-1:0], in_col_q}] <= stream_i.pixel;
    end
    pix_rdata_q <= pix_mem[pix_raddr];
  end

  // --------------------------------------------------------------------------
  // Magnitude line memory: written when a magnitude is formed, read to judge.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [ROW_W-1:0] ny;
    logic [COL_W-1:0] nx;
    logic [ROW_W-1:0] ym, yp;
    logic [COL_W-1:0] xm, xp;
    dir_e             sel_dir;
    logic             second;
    ym      = out_row_q - ROW_W'(1);
    yp      = out_row_q + ROW_W'(1);
    xm      = out_col_q - COL_W'(1);
    xp      = out_col_q + COL_W'(1);
    second  = (state_q == S_JUDGE_B);
    sel_dir = second ? dir_e'(jc_q[MAGDIR_W-1 -: DIR_W]) :
                       dir_e'(mag_rdata_q[MAGDIR_W-1 -: DIR_W]);
    unique case (sel_dir)
      DIR_HORZ: begin
        ny = out_row_q;
        nx = second ? xp : xm;
      end
      DIR_DIAG_SAME: begin
        ny = second ? yp : ym;
        nx = second ? xp : xm;
      end
      DIR_VERT: begin
        ny = second ? yp : ym;
        nx = out_col_q;
      end
      DIR_DIAG_OPP: begin
        ny = second ? yp : ym;
        nx = second ? xm : xp;
      end
    endcase
    if (state_q == S_JUDGE_CHK) begin
      mag_raddr = {out_row_q[LINE_SEL_W-1:0], out_col_q};
    end else begin
      mag_raddr = {ny[LINE_SEL_W-1:0], nx};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mag_we) begin
      mag_mem[{job_y_q[LINE_SEL_W-1:0], job_x_q}] <= {dir_q, sqrt_root};
    end
    mag_rdata_q <= mag_mem[mag_raddr];
  end

  // --------------------------------------------------------------------------
  // Gradient arithmetic: magnitudes, squares and sector compares.
  // --------------------------------------------------------------------------
  assign ax = MAG_W'(gx_q[GRAD_W-1] ? -gx_q : gx_q);
  assign ay = MAG_W'(gy_q[GRAD_W-1] ? -gy_q : gy_q);
  assign sq_sum = {1'b0, ax2_q} + {1'b0, ay2_q};

  always_comb begin
    if ({2'b00, ay_sh_q} <= lo_q) begin
      dir_d = DIR_HORZ;
    end else if ({2'b00, ay_sh_q} > hi_q) begin
      dir_d = DIR_VERT;
    end else if (same_sign_q) begin
      dir_d = DIR_DIAG_SAME;
    end else begin
      dir_d = DIR_DIAG_OPP;
    end
  end

  sng_sqrt u_sng_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sq_sum[SQ_IN_W-1:0]),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // --------------------------------------------------------------------------
  // Judging: border positions pass, inner ones compare along the sector.
  // --------------------------------------------------------------------------
  assign judge_go = (kind_q == KIND_PIXEL) && (out_pos_q < total_q) &&
                    (last_q ||
                     (({1'b0, out_pos_q} +
                       (POS_W+1)'({width_q, 1'b0} + (WIDTH_W+1)'(2))) <=
                      {1'b0, in_pos_q}));
  assign border = (out_row_q == '0) || (out_col_q == '0) ||
                  (out_row_q == height_q - ROW_W'(1)) ||
                  ({1'b0, out_col_q} == width_q - WIDTH_W'(1));
  assign frame_last = (out_pos_q == total_q - POS_W'(1));
  assign judged = ((jc_q[MAG_W-1:0] >= na_q) &&
                   (jc_q[MAG_W-1:0] >= mag_rdata_q[MAG_W-1:0])) ?
                  jc_q[MAG_W-1:0] : '0;

  // --------------------------------------------------------------------------
  // Sequencer: next state and strobes.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d         = state_q;
    stream_i.ready  = 1'b0;
    sqrt_start      = 1'b0;
    mag_we          = 1'b0;
    q_ctrl          = '0;
    q_ctrl.clear    = restart;
    q_wdata.frame_end = frame_last;
    q_wdata.strength  = judged;
    unique case (state_q)
      S_IDLE: begin
        stream_i.ready = 1'b1;
        if (stream_i.valid) begin
          state_d = S_PLAN;
        end
      end
      S_PLAN:     state_d = S_MAG_NEXT;
      S_MAG_NEXT: state_d = (jobs_q != '0) ? S_MAG_RD : S_JUDGE_CHK;
      S_MAG_RD: begin
        if (tap_q == 3'd7) begin
          state_d = S_MAG_LAST;
        end
      end
      S_MAG_LAST: state_d = S_MAG_MUL;
      S_MAG_MUL:  state_d = S_MAG_DIR;
      S_MAG_DIR: begin
        sqrt_start = 1'b1;
        state_d    = S_MAG_SQRT;
      end
      S_MAG_SQRT: begin
        if (sqrt_done) begin
          mag_we  = 1'b1;
          state_d = S_MAG_NEXT;
        end
      end
      S_JUDGE_CHK: state_d = judge_go ? S_JUDGE_A : S_POP;
      S_JUDGE_A: begin
        if (border) begin
          q_ctrl.push      = 1'b1;
          q_wdata.strength = mag_rdata_q[MAG_W-1:0];
          state_d          = S_JUDGE_CHK;
        end else begin
          state_d = S_JUDGE_B;
        end
      end
      S_JUDGE_B: state_d = S_JUDGE_D;
      S_JUDGE_D: begin
        q_ctrl.push = 1'b1;
        state_d     = S_JUDGE_CHK;
      end
      S_POP: begin
        if (q_empty) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || result_o.ready) begin
          q_ctrl.pop = 1'b1;
          state_d    = S_POP_DATA;
        end
      end
      S_POP_DATA: state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stream positions and per-item control state.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_pos_q  <= '0;
      out_pos_q <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      kind_q    <= KIND_FLUSH;
      last_q    <= 1'b0;
      jobs_q    <= '0;
    end else if (restart) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_pos_q  <= '0;
      out_pos_q <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            kind_q <= stream_i.kind;
          end
        end
        // Which magnitudes this pixel completes, and whether it ends the frame.
        S_PLAN: begin
          last_q    <= (kind_q == KIND_PIXEL) && (in_pos_q == total_q - POS_W'(1));
          jobs_q[0] <= (kind_q == KIND_PIXEL) && (in_row_q != '0) && (in_col_q != '0);
          jobs_q[1] <= (kind_q == KIND_PIXEL) && (in_row_q != '0) &&
                       ({1'b0, in_col_q} == width_q - WIDTH_W'(1));
          jobs_q[2] <= (kind_q == KIND_PIXEL) && (in_col_q != '0) &&
                       (in_row_q == height_q - ROW_W'(1));
          jobs_q[3] <= (kind_q == KIND_PIXEL) &&
                       (in_row_q == height_q - ROW_W'(1)) &&
                       ({1'b0, in_col_q} == width_q - WIDTH_W'(1));
        end
        S_MAG_NEXT: begin
          priority if (jobs_q[0]) begin
            jobs_q[0] <= 1'b0;
          end else if (jobs_q[1]) begin
            jobs_q[1] <= 1'b0;
          end else if (jobs_q[2]) begin
            jobs_q[2] <= 1'b0;
          end else begin
            jobs_q[3] <= 1'b0;
          end
        end
        S_JUDGE_CHK: begin
          if (!judge_go && (kind_q == KIND_PIXEL)) begin
            // Judging done: at frame end rewind the output side and the input position, else step the input.
            if (last_q) begin
              out_pos_q <= '0;
              out_row_q <= '0;
              out_col_q <= '0;
              in_pos_q  <= '0;
            end else begin
              in_pos_q <= in_pos_q + POS_W'(1);
            end
            if ({1'b0, in_col_q} == width_q - WIDTH_W'(1)) begin
              in_col_q <= '0;
              in_row_q <= (in_row_q == height_q - ROW_W'(1)) ? '0 :
                          in_row_q + ROW_W'(1);
            end else begin
              in_col_q <= in_col_q + COL_W'(1);
            end
          end
        end
        S_JUDGE_A, S_JUDGE_D: begin
          if ((state_q == S_JUDGE_D) || border) begin
            out_pos_q <= out_pos_q + POS_W'(1);
            if ({1'b0, out_col_q} == width_q - WIDTH_W'(1)) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + ROW_W'(1);
            end else begin
              out_col_q <= out_col_q + COL_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Gradient datapath registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    acc_vld_q <= (state_q == S_MAG_RD);
    acc_tap_q <= tap_q;
    if (state_q == S_MAG_NEXT) begin
      gx_q  <= '0;
      gy_q  <= '0;
      tap_q <= '0;
      priority if (jobs_q[0]) begin
        job_y_q <= in_row_q - ROW_W'(1);
        job_x_q <= in_col_q - COL_W'(1);
      end else if (jobs_q[1]) begin
        job_y_q <= in_row_q - ROW_W'(1);
        job_x_q <= in_col_q;
      end else if (jobs_q[2]) begin
        job_y_q <= in_row_q;
        job_x_q <= in_col_q - COL_W'(1);
      end else begin
        job_y_q <= in_row_q;
        job_x_q <= in_col_q;
      end
    end else begin
      if (state_q == S_MAG_RD) begin
        tap_q <= tap_q + 3'd1;
      end
      if (acc_vld_q) begin
        gx_q <= gx_q + tap_gx(acc_tap_q, pix_rdata_q);
        gy_q <= gy_q + tap_gy(acc_tap_q, pix_rdata_q);
      end
    end
    if (state_q == S_MAG_MUL) begin
      ax2_q       <= ax * ax;
      ay2_q       <= ay * ay;
      ay_sh_q     <= {ay, 15'd0};
      lo_q        <= (MAG_W+17)'(ax) * (MAG_W+17)'(TAN_LOW_Q15);
      hi_q        <= (MAG_W+17)'(ax) * (MAG_W+17)'(TAN_HIGH_Q15);
      same_sign_q <= ((gx_q > 0) == (gy_q > 0));
    end
    if (state_q == S_MAG_DIR) begin
      dir_q <= dir_d;
    end
    if (state_q == S_JUDGE_A) begin
      jc_q <= mag_rdata_q;
    end
    if (state_q == S_JUDGE_B) begin
      na_q <= mag_rdata_q[MAG_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Result queue and output register.
  // --------------------------------------------------------------------------
  sng_queue u_sng_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (q_ctrl),
    .wdata_i (q_wdata),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_POP_DATA) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_POP_DATA) begin
      out_data_q <= q_rdata;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.edge_strength = out_data_q.strength;
  assign result_o.frame_end     = out_data_q.frame_end;

endmodule

`default_nettype wire

>>> src/sng_checker.sv
// ----------------------------------------------------------------------------
// sng_checker: port-level checks of the Sobel non-maximum suppression core
// Watches the request channels of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sng_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [sng_pkg::MAG_W-1:0]  out_strength_i,
  input logic                       out_frame_end_i
);
  import sng_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_strength_i) && $stable(out_frame_end_i))
    else $error("result payload changed while stalled");

  // The core works on one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in work");

  // An edge strength never exceeds the largest Sobel magnitude.
  a_strength_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_strength_i <= MAG_W'(1442))
    else $error("edge strength out of range");

endmodule

bind sobel_gradient_nonmax_suppress_core sng_checker u_sng_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (stream_i.valid),
  .in_ready_i      (stream_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .out_strength_i  (result_o.edge_strength),
  .out_frame_end_i (result_o.frame_end)
);

`default_nettype wire

>>> tb/sv/sng_edge_checker.sv
// ----------------------------------------------------------------------------
// sng_edge_checker: result predictor and scoreboard of the Sobel NMS core
// Watches the pixel, result and configuration channels. It keeps its own
// line stores, raster positions and result queue. From these it works out
// the thinned edge strength of every judged position and compares each
// returned result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sng_edge_checker
  import sng_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  sng_in_if     in_mon,
  sng_out_if    out_mon,
  sng_cfg_if    cfg_mon,
  output int    error_count_o,
  output int    pending_o
);

  // Shadow state of the core.
  logic [PIX_W-1:0]    pix_store [0:LINE_DEPTH-1];
  logic [MAGDIR_W-1:0] grad_store [0:LINE_DEPTH-1];
  int unsigned         col_pos, row_pos, judge_pos;
  int unsigned         width_cfg, height_cfg;
  q_entry_t            formed_q[$];
  q_entry_t            awaited_q[$];

  assign pending_o = awaited_q.size();

  // Reflect-101 border index.
  function automatic int unsigned reflect_idx(int i, int unsigned n);
    if (i < 0) return 1;
    if (i >= int'(n)) return n - 2;
    return i;
  endfunction

  function automatic int pix_at(int y, int x);
    int unsigned ry, rx;
    ry = reflect_idx(y, height_cfg);
    rx = reflect_idx(x, width_cfg);
    return int'(pix_store[(ry % 4) * MAX_WIDTH + rx]);
  endfunction

  function automatic int unsigned floor_root(int unsigned v);
    int unsigned res, bitv;
    res = 0;
    bitv = 1 << 30;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Gradient magnitude and sector of one position, stored in the gradient lines.
  function automatic void form_gradient(int y, int x);
    int          gx, gy;
    longint      ax, ay;
    logic [MAG_W-1:0] mag;
    dir_e        sector;
    gx = (pix_at(y-1, x+1) + 2*pix_at(y, x+1) + pix_at(y+1, x+1))
       - (pix_at(y-1, x-1) + 2*pix_at(y, x-1) + pix_at(y+1, x-1));
    gy = (pix_at(y+1, x-1) + 2*pix_at(y+1, x) + pix_at(y+1, x+1))
       - (pix_at(y-1, x-1) + 2*pix_at(y-1, x) + pix_at(y-1, x+1));
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    mag = MAG_W'(floor_root(int'(ax*ax + ay*ay)));
    if (ay * 32768 <= ax * longint'(TAN_LOW_Q15)) sector = DIR_HORZ;
    else if (ay * 32768 > ax * longint'(TAN_HIGH_Q15)) sector = DIR_VERT;
    else if ((gx > 0) == (gy > 0)) sector = DIR_DIAG_SAME;
    else sector = DIR_DIAG_OPP;
    grad_store[(y % 4) * MAX_WIDTH + x] = {sector, mag};
  endfunction

  function automatic logic [MAG_W-1:0] grad_mag(int y, int x);
    logic [MAGDIR_W-1:0] e;
    e = grad_store[(y % 4) * MAX_WIDTH + x];
    return e[MAG_W-1:0];
  endfunction

  // Suppressed strength of one position; borders pass unchanged.
  function automatic logic [MAG_W-1:0] suppress(int y, int x);
    logic [MAGDIR_W-1:0] centre;
    logic [MAG_W-1:0]    mag, na, nb;
    dir_e                sector;
    centre = grad_store[(y % 4) * MAX_WIDTH + x];
    mag    = centre[MAG_W-1:0];
    sector = dir_e'(centre[MAGDIR_W-1:MAG_W]);
    if (y == 0 || x == 0 || y == int'(height_cfg) - 1 || x == int'(width_cfg) - 1)
      return mag;
    case (sector)
      DIR_HORZ: begin
        na = grad_mag(y, x-1);   nb = grad_mag(y, x+1);
      end
      DIR_DIAG_SAME: begin
        na = grad_mag(y-1, x-1); nb = grad_mag(y+1, x+1);
      end
      DIR_VERT: begin
        na = grad_mag(y-1, x);   nb = grad_mag(y+1, x);
      end
      default: begin
        na = grad_mag(y-1, x+1); nb = grad_mag(y+1, x-1);
      end
    endcase
    return (mag >= na && mag >= nb) ? mag : '0;
  endfunction

  function automatic void restart_stream();
    col_pos = 0;
    row_pos = 0;
    judge_pos = 0;
    formed_q.delete();
  endfunction

  // One accepted request: form what it makes ready, then hand out the oldest.
  function automatic void take_request(logic kind, logic [PIX_W-1:0] pixel);
    int unsigned w, h, total, p, c, r;
    bit          last;
    q_entry_t    e;
    if (kind == KIND_PIXEL) begin
      w = width_cfg;
      h = height_cfg;
      r = row_pos;
      c = col_pos;
      total = w * h;
      p = r * w + c;
      last = (p == total - 1);
      pix_store[(r % 4) * MAX_WIDTH + c] = pixel;
      if (r >= 1 && c >= 1) begin
        form_gradient(r-1, c-1);
        if (c == w - 1) form_gradient(r-1, c);
      end
      if (r == h - 1 && c >= 1) begin
        form_gradient(r, c-1);
        if (c == w - 1) form_gradient(r, c);
      end
      while (judge_pos < total && (last || judge_pos + 2*w + 2 <= p)) begin
        if (formed_q.size() < QDEPTH) begin
          e.strength  = suppress(judge_pos / w, judge_pos % w);
          e.frame_end = (judge_pos == total - 1);
          formed_q.push_back(e);
        end
        judge_pos++;
      end
      if (last) judge_pos = 0;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
    end
    if (formed_q.size() != 0) awaited_q.push_back(formed_q.pop_front());
  endfunction

  // Channel monitor; results are compared before the new request is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [11:0] v;
    q_entry_t    exp_e;
    if (!rst_ni) begin
      width_cfg  = 640;
      height_cfg = 480;
      error_count_o = 0;
      awaited_q.delete();
      restart_stream();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result strength %0d frame_end %0b", $realtime,
                   out_mon.edge_strength, out_mon.frame_end);
          error_count_o++;
        end else begin
          exp_e = awaited_q.pop_front();
          if (exp_e.strength !== out_mon.edge_strength) begin
            $display("%0t: edge_strength expected %0d actual %0d", $realtime,
                     exp_e.strength, out_mon.edge_strength);
            error_count_o++;
          end
          if (exp_e.frame_end !== out_mon.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b", $realtime,
                     exp_e.frame_end, out_mon.frame_end);
            error_count_o++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_IDX_FRAME_WIDTH) begin
          v = cfg_mon.data & 12'h7FF;
          width_cfg = (v < 3) ? 3 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
          restart_stream();
        end else if (cfg_mon.index == CFG_IDX_FRAME_HEIGHT) begin
          v = cfg_mon.data;
          height_cfg = (v < 3) ? 3 : (v > HEIGHT_LIMIT) ? HEIGHT_LIMIT : v;
          restart_stream();
        end
      end
      if (in_mon.valid && in_mon.ready) take_request(in_mon.kind, in_mon.pixel);
    end
  end

endmodule

>>> tb/sv/sobel_gradient_nonmax_suppress_core_tb.sv
// ----------------------------------------------------------------------------
// sobel_gradient_nonmax_suppress_core_tb: stimulus and verdict
// Streams directed and random frames of several geometries into the core,
// with flush requests, bursty input and a stalling receiver. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_gradient_nonmax_suppress_core_tb;
  import sng_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(5);
  localparam int SETTLE_CYCLES = 400;
  localparam int IDLE_LIMIT    = 60000;

  logic clk, rst_n;
  int   error_count, pending;
  int   idle_cycles;
  int   burst_left;
  bit   gaps_on;
  int   stall_mode;

  sng_in_if  in_ch();
  sng_out_if out_ch();
  sng_cfg_if cfg_ch();

  sobel_gradient_nonmax_suppress_core u_top (
    .clk_i(clk), .rst_ni(rst_n), .stream_i(in_ch), .result_o(out_ch), .cfg_i(cfg_ch)
  );

  sng_edge_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .error_count_o(error_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stall pattern: always ready, ready at random, or rarely ready.
  always @(negedge clk) begin
    case (stall_mode)
      0:       out_ch.ready = 1'b1;
      1:       out_ch.ready = ($urandom_range(0, 99) < 60);
      default: out_ch.ready = ($urandom_range(0, 99) < 15);
    endcase
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sobel_gradient_nonmax_suppress_core_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One request on the pixel channel, in bursts, with random gaps when gaps_on is set.
  task automatic send(logic kind, logic [PIX_W-1:0] pix);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        in_ch.valid = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.kind  = kind;
    in_ch.pixel = pix;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain_flushes(int n);
    repeat (n) send(KIND_FLUSH, PIX_W'($urandom));
  endtask

  // Register write once no result is pending, after a settle time.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Pixel of a random frame in one of several textures.
  function automatic logic [PIX_W-1:0] texture(int style, int r, int c);
    case (style)
      0:       return PIX_W'($urandom);
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2:       return PIX_W'(r * 40 + c * 25 + $urandom_range(0, 7));
      default: return ((r + c) % 3 == 0) ? 8'hFF : PIX_W'($urandom_range(0, 20));
    endcase
  endfunction

  initial begin
    int w, h, style, stop_at, n;
    bit held;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind  = KIND_PIXEL;
    in_ch.pixel = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b1;
    idle_cycles = 0;
    burst_left = 0;
    gaps_on = 1'b0;
    stall_mode = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Smallest frame: flush with nothing queued, zero gradient, extremes.
    write_reg(CFG_IDX_FRAME_WIDTH, 12'd3);
    write_reg(CFG_IDX_FRAME_HEIGHT, 12'd3);
    send(KIND_FLUSH, 8'hFF);
    repeat (9) send(KIND_PIXEL, 8'h00);
    drain_flushes(10);
    for (int i = 0; i < 9; i++) begin
      send(KIND_PIXEL, (i % 2) ? 8'hFF : 8'h00);
      if (i == 4) send(KIND_FLUSH, 8'h00);
    end
    drain_flushes(10);

    // Out-of-range and spare register writes; the spare index is ignored.
    write_reg(CFG_IDX_FRAME_WIDTH, 12'h000);
    write_reg(CFG_IDX_SPARE, 12'hABC);
    write_reg(CFG_IDX_FRAME_HEIGHT, 12'h000);
    for (int i = 0; i < 9; i++) send(KIND_PIXEL, PIX_W'(i * 31));
    drain_flushes(10);

    // The width register keeps only its low eleven bits.
    stall_mode = 1;
    write_reg(CFG_IDX_FRAME_WIDTH, 12'h803);
    write_reg(CFG_IDX_FRAME_HEIGHT, 12'd3);
    for (int i = 0; i < 9; i++) send(KIND_PIXEL, texture(i % 4, i / 3, i % 3));
    drain_flushes(10);

    // Tallest frame, only its first rows.
    write_reg(CFG_IDX_FRAME_WIDTH, 12'd3);
    write_reg(CFG_IDX_FRAME_HEIGHT, 12'd4095);
    for (int i = 0; i < 15; i++) send(KIND_PIXEL, PIX_W'($urandom));
    drain_flushes(10);

    // Random frames of small sizes, with stray flushes and aborted frames.
    n = 0;
    held = 1'b0;
    while (n < 200) begin
      w = $urandom_range(3, 8);
      h = $urandom_range(3, 6);
      style = $urandom_range(0, 3);
      gaps_on = $urandom_range(0, 3) != 0;
      stall_mode = $urandom_range(0, 2);
      stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h - 1) : w * h;
      write_reg(CFG_IDX_FRAME_WIDTH, CFG_DATA_W'(w));
      write_reg(CFG_IDX_FRAME_HEIGHT, CFG_DATA_W'(h));
      for (int i = 0; i < stop_at; i++) begin
        if ($urandom_range(0, 9) == 0) send(KIND_FLUSH, PIX_W'($urandom));
        if (!held && n > 100 && i == w + 1) begin
          while (pending != 0) @(negedge clk);
          held = 1'b1;
        end
        send(KIND_PIXEL, texture(style, i / w, i % w));
        n++;
      end
      drain_flushes(2 * w + 4);
    end

    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("sobel_gradient_nonmax_suppress_core_tb: clean");
    end else begin
      $display("sobel_gradient_nonmax_suppress_core_tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/sng_pkg.sv
src/sng_if.sv
src/sng_sqrt.sv
src/sng_queue.sv
src/sobel_gradient_nonmax_suppress_core.sv
src/sng_checker.sv
tb/sv/sng_edge_checker.sv
tb/sv/sobel_gradient_nonmax_suppress_core_tb.sv
